// ----- hdl/universal_joint_rotation_core_defines.svh -----
// ----------------------------------------------------------------------------
// Universal joint rotation core assertion macros
// Immediate-cycle and next-cycle implication checks with reset masking.
// ----------------------------------------------------------------------------
`ifndef UNIVERSAL_JOINT_ROTATION_CORE_DEFINES_SVH
`define UNIVERSAL_JOINT_ROTATION_CORE_DEFINES_SVH

`define UJR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define UJR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/ujr_pkg.sv -----
// ----------------------------------------------------------------------------
// Universal joint rotation package
// Fixed-point formats, CORDIC constants and item types.
// ----------------------------------------------------------------------------
`default_nettype none

package ujr_pkg;

   localparam int TRIG_STAGES_DEF = 14;
   localparam int ATAN_DEPTH      = 24;
   localparam int DATA_W          = 16;
   localparam int CW              = 34;
   localparam int ANGLE_SHIFT     = 17;
   localparam int TRIG_SHIFT      = 16;
   localparam int PROD_SHIFT      = 14;
   localparam int PROD_W          = 2 * DATA_W;

   typedef logic signed [DATA_W-1:0] sample_type;
   typedef logic signed [CW-1:0]     cordic_word_type;
   typedef logic signed [PROD_W-1:0] product_type;

   localparam cordic_word_type PI_Q30       = 34'sd3373259426;
   localparam cordic_word_type HALF_PI_Q30  = 34'sd1686629713;
   localparam cordic_word_type INV_GAIN_Q30 = 34'sd652032874;
   localparam cordic_word_type TRIG_RND     = 34'sd32768;
   localparam product_type     PROD_RND     = 32'sd8192;
   localparam sample_type      ONE_Q14      = 16'sd16384;
   localparam sample_type      SAT_MAX      = 16'sh7fff;
   localparam sample_type      SAT_MIN      = 16'sh8000;

   localparam cordic_word_type ATAN_Q30 [ATAN_DEPTH] = '{
      34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
      34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
      34'sd4194283,   34'sd2097149,   34'sd1048575,   34'sd524287,
      34'sd262143,    34'sd131071,    34'sd65535,     34'sd32767,
      34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
      34'sd1023,      34'sd511,       34'sd255,       34'sd127
   };

   typedef struct packed {
      sample_type angle_first;
      sample_type angle_second;
      sample_type rate_first;
      sample_type rate_second;
   } req_type;

   typedef struct packed {
      sample_type rot_00;
      sample_type rot_10;
      sample_type rot_20;
      sample_type rot_11;
      sample_type rot_21;
      sample_type rot_02;
      sample_type rot_12;
      sample_type rot_22;
      sample_type deriv_x;
      sample_type deriv_z;
   } rsp_type;

   typedef struct packed {
      sample_type cos_v;
      sample_type sin_v;
   } trig_type;

endpackage

`default_nettype wire

// ----- hdl/ujr_chan_if.sv -----
// ----------------------------------------------------------------------------
// Universal joint rotation stream channel
// Valid/ready channel carrying one item per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ujr_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/ujr_cordic_lane.sv -----
// ----------------------------------------------------------------------------
// Universal joint rotation CORDIC lane
// Quadrant fold, one registered rotation per stage, round and clamp to Q1.14.
// ----------------------------------------------------------------------------
`default_nettype none

module ujr_cordic_lane #(
   parameter int TRIG_STAGES = ujr_pkg::TRIG_STAGES_DEF
) (
   input  logic                 clock,
   input  logic                 enable,
   input  ujr_pkg::sample_type  angle,
   output ujr_pkg::trig_type    trig
);

   localparam int CW = ujr_pkg::CW;
   localparam int SW = CW + 1;
   localparam int RW = SW - ujr_pkg::TRIG_SHIFT;
   localparam logic signed [RW-1:0] LIM_HI = RW'(ujr_pkg::ONE_Q14);
   localparam logic signed [RW-1:0] LIM_LO = -LIM_HI;

   ujr_pkg::cordic_word_type x_ff [TRIG_STAGES+1];
   ujr_pkg::cordic_word_type y_ff [TRIG_STAGES+1];
   ujr_pkg::cordic_word_type z_ff [TRIG_STAGES+1];
   logic                     flip_ff [TRIG_STAGES+1];
   ujr_pkg::cordic_word_type z_wide;
   ujr_pkg::cordic_word_type z_fold;
   logic                     flip_fold;
   ujr_pkg::trig_type        trig_ff;

   function automatic ujr_pkg::sample_type round_q14(input ujr_pkg::cordic_word_type v);
      logic signed [SW-1:0] sum;
      logic signed [RW-1:0] shr;
      ujr_pkg::sample_type  res;
      sum = SW'(v) + SW'(ujr_pkg::TRIG_RND);
      shr = sum[SW-1:ujr_pkg::TRIG_SHIFT];
      if (shr > LIM_HI) begin
         res = ujr_pkg::ONE_Q14;
      end else if (shr < LIM_LO) begin
         res = -ujr_pkg::ONE_Q14;
      end else begin
         res = shr[ujr_pkg::DATA_W-1:0];
      end
      return res;
   endfunction

   // fold angles beyond a quarter turn back into range, negate cosine later
   always_comb begin
      z_wide = CW'(angle) <<< ujr_pkg::ANGLE_SHIFT;
      priority if (z_wide > ujr_pkg::HALF_PI_Q30) begin
         z_fold    = ujr_pkg::PI_Q30 - z_wide;
         flip_fold = 1'b1;
      end else if (z_wide < -ujr_pkg::HALF_PI_Q30) begin
         z_fold    = -ujr_pkg::PI_Q30 - z_wide;
         flip_fold = 1'b1;
      end else begin
         z_fold    = z_wide;
         flip_fold = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff[0]    <= ujr_pkg::INV_GAIN_Q30;
         y_ff[0]    <= '0;
         z_ff[0]    <= z_fold;
         flip_ff[0] <= flip_fold;
      end
   end

   for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_stage
      always_ff @(posedge clock) begin
         if (enable) begin
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - ujr_pkg::ATAN_Q30[i];
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + ujr_pkg::ATAN_Q30[i];
            end
            flip_ff[i+1] <= flip_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         trig_ff.cos_v <= flip_ff[TRIG_STAGES] ? -round_q14(x_ff[TRIG_STAGES])
                                               : round_q14(x_ff[TRIG_STAGES]);
         trig_ff.sin_v <= round_q14(y_ff[TRIG_STAGES]);
      end
   end

   assign trig = trig_ff;

endmodule

`default_nettype wire

// ----- hdl/ujr_merge.sv -----
// ----------------------------------------------------------------------------
// Universal joint rotation merge stage
// Cross products of both lanes and rate, then round, negate and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module ujr_merge (
   input  logic                clock,
   input  logic                enable,
   input  ujr_pkg::trig_type   trig_first,
   input  ujr_pkg::trig_type   trig_second,
   input  ujr_pkg::sample_type rate,
   output ujr_pkg::rsp_type    data
);

   localparam int PW = ujr_pkg::PROD_W;
   localparam int SW = PW + 1;
   localparam int RW = SW - ujr_pkg::PROD_SHIFT;
   localparam int DW = ujr_pkg::DATA_W;
   localparam logic signed [RW-1:0] SAT_HI = RW'(ujr_pkg::SAT_MAX);
   localparam logic signed [RW-1:0] SAT_LO = RW'(ujr_pkg::SAT_MIN);

   ujr_pkg::trig_type    t1_ff;
   ujr_pkg::trig_type    t2_ff;
   ujr_pkg::product_type s1s2_ff;
   ujr_pkg::product_type c1s2_ff;
   ujr_pkg::product_type s1c2_ff;
   ujr_pkg::product_type c1c2_ff;
   ujr_pkg::product_type dx_ff;
   ujr_pkg::product_type dz_ff;
   ujr_pkg::sample_type  neg_s2;
   ujr_pkg::rsp_type     data_ff;

   function automatic logic signed [RW-1:0] round_prod(input ujr_pkg::product_type p);
      logic signed [SW-1:0] sum;
      sum = SW'(p) + SW'(ujr_pkg::PROD_RND);
      return sum[SW-1:ujr_pkg::PROD_SHIFT];
   endfunction

   function automatic ujr_pkg::sample_type sat16(input logic signed [RW-1:0] v);
      ujr_pkg::sample_type res;
      if (v > SAT_HI) begin
         res = ujr_pkg::SAT_MAX;
      end else if (v < SAT_LO) begin
         res = ujr_pkg::SAT_MIN;
      end else begin
         res = v[DW-1:0];
      end
      return res;
   endfunction

   function automatic ujr_pkg::sample_type neg16(input logic signed [RW-1:0] v);
      logic signed [RW-1:0] n;
      n = -v;
      return n[DW-1:0];
   endfunction

   function automatic ujr_pkg::sample_type pos16(input logic signed [RW-1:0] v);
      return v[DW-1:0];
   endfunction

   assign neg_s2 = -trig_second.sin_v;

   always_ff @(posedge clock) begin
      if (enable) begin
         t1_ff   <= trig_first;
         t2_ff   <= trig_second;
         s1s2_ff <= trig_first.sin_v * trig_second.sin_v;
         c1s2_ff <= trig_first.cos_v * trig_second.sin_v;
         s1c2_ff <= trig_first.sin_v * trig_second.cos_v;
         c1c2_ff <= trig_first.cos_v * trig_second.cos_v;
         dx_ff   <= neg_s2 * rate;
         dz_ff   <= trig_second.cos_v * rate;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff.rot_00  <= t2_ff.cos_v;
         data_ff.rot_10  <= pos16(round_prod(s1s2_ff));
         data_ff.rot_20  <= neg16(round_prod(c1s2_ff));
         data_ff.rot_11  <= t1_ff.cos_v;
         data_ff.rot_21  <= t1_ff.sin_v;
         data_ff.rot_02  <= t2_ff.sin_v;
         data_ff.rot_12  <= neg16(round_prod(s1c2_ff));
         data_ff.rot_22  <= pos16(round_prod(c1c2_ff));
         data_ff.deriv_x <= sat16(round_prod(dx_ff));
         data_ff.deriv_z <= sat16(round_prod(dz_ff));
      end
   end

   assign data = data_ff;

endmodule

`default_nettype wire

// ----- hdl/universal_joint_rotation_core.sv -----
// ----------------------------------------------------------------------------
// Universal joint rotation core: two CORDIC lanes, one per angle, plus merge.
// Stages in order: fold, TRIG_STAGES rotations, round, 2 merge.
// Throughput: one item per cycle; a stalled result freezes the whole pipeline.
// Reset clears the stage valid bits only; datapath registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "universal_joint_rotation_core_defines.svh"

module universal_joint_rotation_core #(
   parameter int TRIG_STAGES = ujr_pkg::TRIG_STAGES_DEF
) (
   input logic        clock,
   input logic        reset,
   ujr_chan_if.sink   req_if,
   ujr_chan_if.source rsp_if
);

   localparam int LANE_LAT = TRIG_STAGES + 2;
   localparam int LAT      = LANE_LAT + 2;

   logic                 enable;
   logic [LAT-1:0]       vld_ff;
   logic [LAT-1:0]       vld_in;
   ujr_pkg::sample_type  rate_ff [LANE_LAT];
   ujr_pkg::trig_type    trig_first;
   ujr_pkg::trig_type    trig_second;
   ujr_pkg::rsp_type     rsp_data;

   // advance everything unless a finished item waits on the output
   assign enable       = !vld_ff[LAT-1] || rsp_if.ready;
   assign req_if.ready = enable && !reset;
   assign vld_in       = enable ? {vld_ff[LAT-2:0], req_if.valid} : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rate_ff[0] <= req_if.data.rate_second;
         for (int k = 1; k < LANE_LAT; k++) begin
            rate_ff[k] <= rate_ff[k-1];
         end
      end
   end

   ujr_cordic_lane #(
      .TRIG_STAGES (TRIG_STAGES)
   ) u_lane_first (
      .clock  (clock),
      .enable (enable),
      .angle  (req_if.data.angle_first),
      .trig   (trig_first)
   );

   ujr_cordic_lane #(
      .TRIG_STAGES (TRIG_STAGES)
   ) u_lane_second (
      .clock  (clock),
      .enable (enable),
      .angle  (req_if.data.angle_second),
      .trig   (trig_second)
   );

   ujr_merge u_merge (
      .clock       (clock),
      .enable      (enable),
      .trig_first  (trig_first),
      .trig_second (trig_second),
      .rate        (rate_ff[LANE_LAT-1]),
      .data        (rsp_data)
   );

   assign rsp_if.valid = vld_ff[LAT-1];
   assign rsp_if.data  = rsp_data;

   `UJR_ASSERT_NEXT(a_stall_freeze, clock, reset, !enable, $stable(vld_ff), "pipeline moved while stalled")
   `UJR_ASSERT_NEXT(a_valid_shift, clock, reset, enable, vld_ff[LAT-1] == $past(vld_ff[LAT-2]), "valid lost in pipeline")
   `UJR_ASSERT_NOW(a_trig_range, clock, reset, rsp_if.valid, (rsp_if.data.rot_00 <= ujr_pkg::ONE_Q14) && (rsp_if.data.rot_00 >= -ujr_pkg::ONE_Q14) && (rsp_if.data.rot_02 <= ujr_pkg::ONE_Q14) && (rsp_if.data.rot_02 >= -ujr_pkg::ONE_Q14), "trig output out of range")

endmodule

`default_nettype wire

// ----- verif/universal_joint_rotation_core_test.sv -----
// ----------------------------------------------------------------------------
// Universal joint rotation core testbench
// Drives joint angle and rate items through the valid/ready request channel,
// predicts every rotation entry and subspace derivative with a fixed-point
// CORDIC model of its own, and compares each result item field by field.
// Directed items cover angle extremes, the fold beyond a quarter turn,
// derivative saturation and the unused first rate; random items follow under
// several sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module universal_joint_rotation_core_test;
   import ujr_pkg::*;

   localparam int LATENCY     = TRIG_STAGES_DEF + 4;
   localparam int CYCLE_LIMIT = 400000;
   localparam sample_type ANGLE_PI      = 16'sd25736;
   localparam sample_type ANGLE_HALF_PI = 16'sd12868;

   logic clock;
   logic reset;

   ujr_chan_if #(.payload_type(req_type)) req_chan ();
   ujr_chan_if #(.payload_type(rsp_type)) rsp_chan ();

   universal_joint_rotation_core #(
      .TRIG_STAGES(TRIG_STAGES_DEF)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_chan),
      .rsp_if (rsp_chan)
   );

   rsp_type pending_frames[$];
   rsp_type due_frame;
   int      failures      = 0;
   int      cycle_count   = 0;
   int      send_idle_pct = 0;
   int      rsp_stall_pct = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic longint clamp_range(input longint v, input longint lo, input longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic longint round_product(input longint a, input longint b);
      return (a * b + 8192) >>> PROD_SHIFT;
   endfunction

   function automatic void angle_sincos(input sample_type angle, output longint cos_q14,
                                        output longint sin_q14);
      longint z;
      longint x;
      longint y;
      longint t;
      bit     flip;
      z    = longint'(angle) * 131072;
      x    = longint'(INV_GAIN_Q30);
      y    = 0;
      flip = 1'b0;
      if (z > longint'(HALF_PI_Q30)) begin
         z    = longint'(PI_Q30) - z;
         flip = 1'b1;
      end else if (z < -longint'(HALF_PI_Q30)) begin
         z    = -longint'(PI_Q30) - z;
         flip = 1'b1;
      end
      for (int i = 0; i < TRIG_STAGES_DEF && i < ATAN_DEPTH; i++) begin
         if (z >= 0) begin
            t = x - (y >>> i);
            y = y + (x >>> i);
            z = z - longint'(ATAN_Q30[i]);
         end else begin
            t = x + (y >>> i);
            y = y - (x >>> i);
            z = z + longint'(ATAN_Q30[i]);
         end
         x = t;
      end
      x       = clamp_range((x + 32768) >>> TRIG_SHIFT, -16384, 16384);
      y       = clamp_range((y + 32768) >>> TRIG_SHIFT, -16384, 16384);
      cos_q14 = flip ? -x : x;
      sin_q14 = y;
   endfunction

   function automatic rsp_type predict_joint_frame(input req_type item);
      longint  c1;
      longint  s1;
      longint  c2;
      longint  s2;
      longint  r2;
      rsp_type frame;
      angle_sincos(item.angle_first, c1, s1);
      angle_sincos(item.angle_second, c2, s2);
      r2            = longint'(item.rate_second);
      frame.rot_00  = sample_type'(c2);
      frame.rot_10  = sample_type'(round_product(s1, s2));
      frame.rot_20  = sample_type'(-round_product(c1, s2));
      frame.rot_11  = sample_type'(c1);
      frame.rot_21  = sample_type'(s1);
      frame.rot_02  = sample_type'(s2);
      frame.rot_12  = sample_type'(-round_product(s1, c2));
      frame.rot_22  = sample_type'(round_product(c1, c2));
      frame.deriv_x = sample_type'(clamp_range(round_product(-s2, r2), -32768, 32767));
      frame.deriv_z = sample_type'(clamp_range(round_product(c2, r2), -32768, 32767));
      return frame;
   endfunction

   function automatic req_type make_item(input sample_type a1, input sample_type a2,
                                         input sample_type r1, input sample_type r2);
      req_type item;
      item.angle_first  = a1;
      item.angle_second = a2;
      item.rate_first   = r1;
      item.rate_second  = r2;
      return item;
   endfunction

   function automatic sample_type random_angle();
      int pick;
      pick = $urandom_range(99);
      if (pick < 15) return sample_type'($urandom);
      if (pick < 25) return sample_type'(int'($urandom_range(0, 64)) - 32 +
                                         ($urandom_range(1) ? 12868 : -12868));
      return sample_type'(int'($urandom_range(0, 51472)) - 25736);
   endfunction

   function automatic sample_type random_rate();
      int pick;
      pick = $urandom_range(99);
      if (pick < 5) return SAT_MIN;
      if (pick < 10) return SAT_MAX;
      return sample_type'($urandom);
   endfunction

   task automatic check_field(input string name, input sample_type want, input sample_type got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   task automatic send_item(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data  <= item;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      pending_frames.push_back(predict_joint_frame(item));
   endtask

   task automatic test_angle_extremes();
      send_item(make_item(16'sd0, 16'sd0, 16'sd0, 16'sd0));
      send_item(make_item(ANGLE_PI, -ANGLE_PI, 16'sh5555, 16'sh2aaa));
      send_item(make_item(-ANGLE_PI, ANGLE_PI, -16'sh5556, -16'sh2aab));
      send_item(make_item(ANGLE_HALF_PI - 16'sd1, ANGLE_HALF_PI, 16'sd128, 16'sd128));
      send_item(make_item(-ANGLE_HALF_PI + 16'sd1, -ANGLE_HALF_PI, -16'sd128, -16'sd128));
      send_item(make_item(SAT_MAX, SAT_MIN, SAT_MAX, SAT_MAX));
      send_item(make_item(SAT_MIN, SAT_MAX, SAT_MIN, SAT_MIN));
      send_item(make_item(16'sd6434, -16'sd6434, 16'sd1, -16'sd1));
   endtask

   task automatic test_derivative_saturation();
      send_item(make_item(16'sd0, ANGLE_HALF_PI, 16'sd0, SAT_MIN));
      send_item(make_item(16'sd0, ANGLE_PI, 16'sd0, SAT_MIN));
      send_item(make_item(16'sd0, -ANGLE_HALF_PI, 16'sd0, SAT_MAX));
      send_item(make_item(16'sd0, 16'sd0, 16'sd0, SAT_MIN));
   endtask

   task automatic test_rate_first_ignored();
      sample_type rates [5] = '{16'sd0, SAT_MAX, SAT_MIN, 16'sh5555, -16'sh5556};
      foreach (rates[i]) send_item(make_item(16'sd4000, -16'sd9000, rates[i], 16'sd777));
   endtask

   task automatic test_random_traffic(input int count, input int send_pct, input int stall_pct);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) send_item(make_item(random_angle(), random_angle(), random_rate(),
                                         random_rate()));
   endtask

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_frames.size() == 0) begin
            $error("result item with no expectation pending");
            failures++;
         end else begin
            due_frame = pending_frames.pop_front();
            check_field("rot_00", due_frame.rot_00, rsp_chan.data.rot_00);
            check_field("rot_10", due_frame.rot_10, rsp_chan.data.rot_10);
            check_field("rot_20", due_frame.rot_20, rsp_chan.data.rot_20);
            check_field("rot_11", due_frame.rot_11, rsp_chan.data.rot_11);
            check_field("rot_21", due_frame.rot_21, rsp_chan.data.rot_21);
            check_field("rot_02", due_frame.rot_02, rsp_chan.data.rot_02);
            check_field("rot_12", due_frame.rot_12, rsp_chan.data.rot_12);
            check_field("rot_22", due_frame.rot_22, rsp_chan.data.rot_22);
            check_field("deriv_x", due_frame.deriv_x, rsp_chan.data.deriv_x);
            check_field("deriv_z", due_frame.deriv_z, rsp_chan.data.deriv_z);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      reset          <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.data  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_angle_extremes();
      test_derivative_saturation();
      test_rate_first_ignored();
      test_random_traffic(465, 0, 0);
      test_random_traffic(465, 71, 0);
      test_random_traffic(465, 0, 71);
      test_random_traffic(460, 23, 23);

      // drop valid and drain the pipeline
      req_chan.valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);

      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+hdl
hdl/ujr_pkg.sv
hdl/ujr_chan_if.sv
hdl/ujr_cordic_lane.sv
hdl/ujr_merge.sv
hdl/universal_joint_rotation_core.sv
verif/universal_joint_rotation_core_test.sv
